[rtl/tsd_pkg.sv]
// Shared types, constants and the CRC step for the thermometer scratchpad decoder.
package tsd_pkg;

    localparam int BYTE_W      = 8;
    localparam int FRAME_BYTES = 9;
    localparam int IDX_W       = 4;
    localparam int RAW_W       = 16;
    localparam int TEMP_W      = 19;
    localparam int PROD_W      = 23;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = 1;
    localparam int Q_CNT_W     = 2;

    localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0]  IDX_END      = IDX_W'(FRAME_BYTES);
    localparam logic [IDX_W-1:0]  IDX_B0       = 4'd0;
    localparam logic [IDX_W-1:0]  IDX_B1       = 4'd1;
    localparam logic [IDX_W-1:0]  IDX_B4       = 4'd4;
    localparam logic [IDX_W-1:0]  IDX_B6       = 4'd6;
    localparam logic [IDX_W-1:0]  IDX_B7       = 4'd7;

    localparam logic [BYTE_W-1:0] CRC_POLY     = 8'h8C;
    localparam logic [BYTE_W-1:0] FAMILY_RESET = 8'h28;
    localparam logic [BYTE_W-1:0] FAMILY_NINE  = 8'h10;
    localparam logic [BYTE_W-1:0] COUNT_PER_C  = 8'h10;
    localparam logic [RAW_W-1:0]  COUNT_BIAS   = 16'd12;
    localparam logic [RAW_W-1:0]  NIBBLE_MASK  = 16'hFFF0;
    localparam logic [Q_CNT_W-1:0] Q_FULL_CNT  = Q_CNT_W'(Q_DEPTH);

    // Resolution field, bits 6..5 of the configuration byte
    localparam logic [1:0] RES_9BIT  = 2'b00;
    localparam logic [1:0] RES_10BIT = 2'b01;
    localparam logic [1:0] RES_11BIT = 2'b10;
    localparam logic [1:0] RES_12BIT = 2'b11;

    typedef struct packed {
        logic              crc_ok;
        logic [BYTE_W-1:0] family;
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [1:0]        res;
        logic [BYTE_W-1:0] b6;
        logic [BYTE_W-1:0] b7;
    } t_job;

    typedef struct packed {
        logic vld;
        t_job job;
    } t_job_ch;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [BYTE_W-1:0] crc_step(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/tsd_ifs.sv]
// Handshake channel interfaces for scratchpad bytes, results and configuration.
interface tsd_byte_if import tsd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;
    logic              frame_start;
    modport source (output valid, byte_value, frame_start, input ready);
    modport sink   (input valid, byte_value, frame_start, output ready);
endinterface

interface tsd_res_if import tsd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temp_centi;
    logic                     valid_res;
    modport source (output valid, temp_centi, valid_res, input ready);
    modport sink   (input valid, temp_centi, valid_res, output ready);
endinterface

interface tsd_cfg_if import tsd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] family_code;
    modport source (output valid, family_code, input ready);
    modport sink   (input valid, family_code, output ready);
endinterface

[rtl/thermometer_scratchpad_decoder_top.sv]
// Top level of the thermometer scratchpad decoder: config register, front, queue, back.
//
// Usage: feed the nine scratchpad bytes on i_byte_ch, byte 0 flagged with
// frame_start (a flag mid-frame drops the partial frame without a result).
// Bytes 0 to 7 run through the CRC-8; byte 8 is the check byte. After the
// ninth byte one item leaves on o_res_ch: temperature in hundredths of a
// degree and the CRC verdict (temperature 0 when the check fails).
// i_cfg_ch writes the family code; change it only while no frame is in flight.
// Throughput: one byte per cycle while the queue is not full; the CRC step is a
// combinational update of the CRC register. Path: an accepted check byte enters the
// queue, then is popped into the conversion register once that register is free.
// Reset: the byte count and CRC clear, the family code returns to 0x28,
// the queue empties and no result is offered.
// Stall: when the receiver holds ready low the result waits in the output
// register; up to two further frames park in the queue, after which
// i_byte_ch.ready drops until a frame leaves the queue.
module thermometer_scratchpad_decoder_top import tsd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsd_byte_if.sink  i_byte_ch,
    tsd_cfg_if.sink   i_cfg_ch,
    tsd_res_if.source o_res_ch
);

    logic [BYTE_W-1:0] r_family;
    t_job_ch           w_push;
    t_job_ch           w_head;
    t_q_stat           w_qstat;
    logic              w_pop;

    // Configuration is always taken at once
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_family <= FAMILY_RESET;
        end else if (i_cfg_ch.valid) begin
            r_family <= i_cfg_ch.family_code;
        end
    end

    // Intake and CRC; hand each completed frame to the queue
    tsd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_ch (i_byte_ch),
        .i_family  (r_family),
        .i_qstat   (w_qstat),
        .o_push    (w_push)
    );

    // Decouple intake from a stalled receiver
    tsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    // Convert the frame at the queue head and hold it for the receiver
    tsd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_res_ch (o_res_ch)
    );

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.vld |-> !w_qstat.full)
        else $error("frame pushed into a full queue");

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.vld)
        else $error("pop from an empty queue");

    a_bad_crc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_ch.valid && !o_res_ch.valid_res) |-> (o_res_ch.temp_centi == '0))
        else $error("failed CRC with non-zero temperature");

    a_pop_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_res_ch.valid)
        else $error("popped frame did not reach the output");
`endif

endmodule

[rtl/tsd_front.sv]
// Front end: byte intake, frame position, CRC and capture of the bytes used later.
module tsd_front import tsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tsd_byte_if.sink          i_byte_ch,
    input  logic [BYTE_W-1:0] i_family,
    input  t_q_stat           i_qstat,
    output t_job_ch           o_push
);

    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [BYTE_W-1:0] r_crc, n_crc;
    logic [BYTE_W-1:0] r_b0, r_b1, r_b6, r_b7;
    logic [1:0]        r_res;

    logic              w_acc;
    logic              w_restart;
    logic [IDX_W-1:0]  w_idx;
    logic [BYTE_W-1:0] w_crc;
    logic [BYTE_W-1:0] w_b;

    assign i_byte_ch.ready = !i_qstat.full;
    assign w_acc     = i_byte_ch.valid && i_byte_ch.ready;
    assign w_b       = i_byte_ch.byte_value;
    assign w_restart = i_byte_ch.frame_start || (r_idx >= IDX_END);
    assign w_idx     = w_restart ? '0 : r_idx;
    assign w_crc     = w_restart ? '0 : r_crc;

    always_comb begin
        n_idx = r_idx;
        n_crc = r_crc;
        o_push.vld        = 1'b0;
        o_push.job.crc_ok = (w_crc == w_b);
        o_push.job.family = i_family;
        o_push.job.b0     = r_b0;
        o_push.job.b1     = r_b1;
        o_push.job.res    = r_res;
        o_push.job.b6     = r_b6;
        o_push.job.b7     = r_b7;
        if (w_acc) begin
            if (w_idx < LAST_IDX) begin
                n_idx = w_idx + 1'b1;
                n_crc = crc_step(w_crc, w_b);
            end else begin
                // check byte: hand the frame to the queue, start afresh
                n_idx = '0;
                n_crc = '0;
                o_push.vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_crc <= '0;
        end else begin
            r_idx <= n_idx;
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            if (w_idx == IDX_B0) r_b0  <= w_b;
            if (w_idx == IDX_B1) r_b1  <= w_b;
            if (w_idx == IDX_B4) r_res <= w_b[6:5];
            if (w_idx == IDX_B6) r_b6  <= w_b;
            if (w_idx == IDX_B7) r_b7  <= w_b;
        end
    end

endmodule

[rtl/tsd_queue.sv]
// Two-entry queue of finished frames between front and back end.
module tsd_queue import tsd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_job_ch i_push,
    input  logic    i_pop,
    output t_job_ch o_head,
    output t_q_stat o_stat
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;
    logic               w_wr, w_rd;

    assign o_stat.full  = (r_cnt == Q_FULL_CNT);
    assign o_stat.empty = (r_cnt == '0);
    assign w_wr = i_push.vld && !o_stat.full;
    assign w_rd = i_pop && !o_stat.empty;

    assign o_head.vld = !o_stat.empty;
    assign o_head.job = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        case ({w_wr, w_rd})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) r_wr <= r_wr + 1'b1;
            if (w_rd) r_rd <= r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

endmodule

[rtl/tsd_back.sv]
// Back end: raw value correction, scaling to hundredths and the output register.
module tsd_back import tsd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job_ch   i_head,
    output logic      o_pop,
    tsd_res_if.source o_res_ch
);

    logic                     r_vld;
    logic signed [TEMP_W-1:0] r_temp;
    logic                     r_ok;

    logic [RAW_W-1:0]         w_raw;
    logic [RAW_W-1:0]         w_shift;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_bias;
    logic signed [TEMP_W-1:0] w_temp;

    always_comb begin
        w_shift = {i_head.job.b1, i_head.job.b0} << 3;
        if (i_head.job.family == FAMILY_NINE) begin
            w_raw = w_shift;
            if (i_head.job.b7 == COUNT_PER_C) begin
                w_raw = (w_shift & NIBBLE_MASK) + COUNT_BIAS
                        - {{(RAW_W-BYTE_W){1'b0}}, i_head.job.b6};
            end
        end else begin
            w_raw = {i_head.job.b1, i_head.job.b0};
            case (i_head.job.res)
                RES_9BIT:  w_raw[2:0] = '0;
                RES_10BIT: w_raw[1:0] = '0;
                RES_11BIT: w_raw[0]   = 1'b0;
                RES_12BIT: w_raw      = {i_head.job.b1, i_head.job.b0};
                default:   w_raw      = {i_head.job.b1, i_head.job.b0};
            endcase
        end
    end

    // raw*100/16, rounded toward zero: bias negatives by 15 before the shift
    assign w_prod = $signed({{(PROD_W-RAW_W){w_raw[RAW_W-1]}}, w_raw}) * PROD_W'(100);
    assign w_bias = w_prod + (w_prod[PROD_W-1] ? PROD_W'(15) : PROD_W'(0));
    assign w_temp = w_bias[PROD_W-1:4];

    assign o_pop = i_head.vld && (!r_vld || o_res_ch.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_pop) begin
            r_vld <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ok   <= i_head.job.crc_ok;
            r_temp <= i_head.job.crc_ok ? w_temp : '0;
        end
    end

    assign o_res_ch.valid      = r_vld;
    assign o_res_ch.temp_centi = r_temp;
    assign o_res_ch.valid_res  = r_ok;

endmodule
